@@ hw/rtl/x86alu_pkg.sv @@
`default_nettype none
package x86alu_pkg;

  // Operation codes carried in the command field.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_CMP  = 5'd2,  OP_INC  = 5'd3,
    OP_DEC  = 5'd4,  OP_NEG  = 5'd5,  OP_MUL  = 5'd6,  OP_IMUL = 5'd7,
    OP_DIV  = 5'd8,  OP_IDIV = 5'd9,  OP_AND  = 5'd10, OP_OR   = 5'd11,
    OP_XOR  = 5'd12, OP_TEST = 5'd13, OP_NOT  = 5'd14, OP_SHL  = 5'd15,
    OP_SHR  = 5'd16, OP_SAR  = 5'd17, OP_CLC  = 5'd18, OP_CMC  = 5'd19,
    OP_STC  = 5'd20, OP_CLD  = 5'd21, OP_STD  = 5'd22, OP_CLI  = 5'd23,
    OP_STI  = 5'd24, OP_BRT  = 5'd25
  } op_t;

  // Flag bit positions in the 8086 flag word.
  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 2;
  localparam int unsigned FL_AF = 4;
  localparam int unsigned FL_ZF = 6;
  localparam int unsigned FL_SF = 7;
  localparam int unsigned FL_IF = 9;
  localparam int unsigned FL_DF = 10;
  localparam int unsigned FL_OF = 11;

  localparam int unsigned DIV_STEPS = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic mul_fin;
    logic div_step;
    logic div_fin;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/x86alu_ctrl.sv @@
`default_nettype none
module x86alu_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output x86alu_pkg::dp_cmd_t       cmd,
  input  wire x86alu_pkg::dp_stat_t stat
);
  import x86alu_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Sequencing of one item through the datapath.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_mul) state_next = S_MUL;
        else if (stat.need_div) state_next = S_DIV;
        else state_next = S_OUT;
      end
      S_MUL: begin
        cmd.mul_fin = 1'b1;
        state_next = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

@@ hw/rtl/x86alu_dpath.sv @@
`default_nettype none
module x86alu_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire x86alu_pkg::dp_cmd_t cmd,
  output x86alu_pkg::dp_stat_t     stat,
  input  wire logic [4:0]          command,
  input  wire logic                wide,
  input  wire logic [3:0]          condition,
  input  wire logic [15:0]         operand_a,
  input  wire logic [15:0]         operand_b,
  output logic [15:0]              result,
  output logic                     write_back,
  output logic [15:0]              flags_out,
  output logic                     branch_taken,
  output logic                     divide_error
);
  import x86alu_pkg::*;

  // Sign, zero and parity from a result.
  function automatic logic [15:0] set_common(logic [15:0] f, logic [15:0] r,
                                             logic [15:0] sg);
    logic [15:0] o;
    o = f;
    o[FL_SF] = |(r & sg);
    o[FL_ZF] = (r == 16'h0000);
    o[FL_PF] = ~^r[7:0];
    return o;
  endfunction

  function automatic logic [15:0] set_arith(logic [15:0] f, logic [15:0] r,
                                            logic [15:0] sg, logic cf,
                                            logic of, logic af);
    logic [15:0] o;
    o = f;
    o[FL_CF] = cf;
    o[FL_OF] = of;
    o[FL_AF] = af;
    return set_common(o, r, sg);
  endfunction

  logic [4:0]  op;
  logic        wd;
  logic [3:0]  cond;
  logic [15:0] a, b;
  logic [31:0] prod;
  logic [15:0] rem, quo, dvs;
  logic        qneg;
  logic [3:0]  cnt;
  logic [15:0] flags;

  logic [15:0] mask, sg;
  assign mask = wd ? 16'hffff : 16'h00ff;
  assign sg   = wd ? 16'h8000 : 16'h0080;

  // Operand capture on an input transfer, masked to the width.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= command;
      wd   <= wide;
      cond <= condition;
      a    <= operand_a & (wide ? 16'hffff : 16'h00ff);
      b    <= operand_b & (wide ? 16'hffff : 16'h00ff);
    end
  end

  // Divide setup: magnitudes of the operands and the quotient sign.
  logic        is_div, is_idiv, a_neg, b_neg;
  logic [15:0] a_mag, b_mag;
  assign is_div  = (op == OP_DIV) || (op == OP_IDIV);
  assign is_idiv = (op == OP_IDIV);
  assign a_neg   = is_idiv && |(a & sg);
  assign b_neg   = is_idiv && |(b & sg);
  assign a_mag   = a_neg ? ((~a + 16'd1) & mask) : a;
  assign b_mag   = b_neg ? ((~b + 16'd1) & mask) : b;

  assign stat.need_mul = (op == OP_MUL) || (op == OP_IMUL);
  assign stat.need_div = is_div && (b != 16'h0000);
  assign stat.div_last = (cnt == 4'(DIV_STEPS - 1));

  // Signed 17x17 multiplier covering both mul and imul.
  logic signed [16:0] ma, mb;
  logic signed [33:0] mp;
  assign ma = wd ? $signed({(op == OP_IMUL) & a[15], a})
                 : $signed({{9{(op == OP_IMUL) & a[7]}}, a[7:0]});
  assign mb = wd ? $signed({(op == OP_IMUL) & b[15], b})
                 : $signed({{9{(op == OP_IMUL) & b[7]}}, b[7:0]});
  assign mp = ma * mb;

  // One restoring step of the quotient recurrence.
  logic [16:0] rsh, rdif;
  assign rsh  = {rem, quo[15]};
  assign rdif = rsh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod <= mp[31:0];
      rem  <= 16'h0000;
      quo  <= a_mag;
      dvs  <= b_mag;
      qneg <= a_neg ^ b_neg;
      cnt  <= 4'd0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 4'd1;
      if (!rdif[16]) begin
        rem <= rdif[15:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= rsh[15:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  // Operations finished in the execute state, shifts included.
  logic [16:0] add_u;
  logic [15:0] sub_u, inc_r, dec_r, neg_r, lg_r;
  logic [4:0]  nib;
  logic [5:0]  sh_n;
  logic [48:0] shl_v;
  logic [49:0] shr_v;
  logic [15:0] sh_r;
  logic        sh_cf;
  logic        cc_t;
  logic [15:0] res_n, flg_n;
  logic        wb_n, br_n, de_n, wr_n;

  assign add_u = {1'b0, a} + {1'b0, b};
  assign sub_u = a - b;
  assign nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
  assign inc_r = (a + 16'd1) & mask;
  assign dec_r = (a - 16'd1) & mask;
  assign neg_r = (16'd0 - a) & mask;
  assign lg_r  = (op == OP_OR) ? (a | b) : (op == OP_XOR) ? (a ^ b) : (a & b);
  assign sh_n  = (b > 16'd32) ? 6'd32 : b[5:0];
  assign shl_v = {33'b0, a} << sh_n;
  assign shr_v = {((op == OP_SAR) && |(a & sg))
                    ? {33'h1ffffffff, a | ~mask} : {33'b0, a}, 1'b0} >> sh_n;
  assign sh_r  = (op == OP_SHL) ? (shl_v[15:0] & mask) : (shr_v[16:1] & mask);
  assign sh_cf = (op == OP_SHL) ? (wd ? shl_v[16] : shl_v[8]) : shr_v[0];

  // Branch condition on the kept flags.
  always_comb begin
    case (cond[3:1])
      3'd0:    cc_t = flags[FL_OF];
      3'd1:    cc_t = flags[FL_CF];
      3'd2:    cc_t = flags[FL_ZF];
      3'd3:    cc_t = flags[FL_CF] | flags[FL_ZF];
      3'd4:    cc_t = flags[FL_SF];
      3'd5:    cc_t = flags[FL_PF];
      3'd6:    cc_t = flags[FL_SF] ^ flags[FL_OF];
      default: cc_t = (flags[FL_SF] ^ flags[FL_OF]) | flags[FL_ZF];
    endcase
  end

  // Next output item and flag word.
  logic [15:0] mul_r, q_r;
  logic        mul_hi;
  assign mul_r  = prod[15:0] & mask;
  assign mul_hi = (op == OP_IMUL)
                  ? (wd ? (prod[31:16] != {16{prod[15]}}) : (prod[31:8] != {24{prod[7]}}))
                  : (wd ? (prod[31:16] != 16'h0000) : (prod[15:8] != 8'h00));
  assign q_r    = (qneg ? (~quo + 16'd1) : quo) & mask;

  always_comb begin
    res_n = 16'h0000;
    flg_n = flags;
    wb_n  = 1'b0;
    br_n  = 1'b0;
    de_n  = 1'b0;
    wr_n  = 1'b0;
    if (cmd.mul_fin) begin
      wr_n  = 1'b1;
      res_n = mul_r;
      wb_n  = 1'b1;
      flg_n = set_arith(flags, mul_r, sg, mul_hi, mul_hi, 1'b0);
    end else if (cmd.div_fin) begin
      wr_n  = 1'b1;
      res_n = q_r;
      wb_n  = 1'b1;
      flg_n = set_arith(flags, q_r, sg, 1'b0, 1'b0, 1'b0);
    end else if (cmd.exec && !stat.need_mul && !stat.need_div) begin
      wr_n = 1'b1;
      case (op)
        OP_ADD: begin
          res_n = add_u[15:0] & mask;
          wb_n  = 1'b1;
          flg_n = set_arith(flags, add_u[15:0] & mask, sg, wd ? add_u[16] : add_u[8],
                            |(~(a ^ b) & (a ^ add_u[15:0]) & sg), nib[4]);
        end
        OP_SUB, OP_CMP: begin
          res_n = (op == OP_SUB) ? (sub_u & mask) : 16'h0000;
          wb_n  = (op == OP_SUB);
          flg_n = set_arith(flags, sub_u & mask, sg, b > a,
                            |((a ^ b) & (a ^ sub_u) & sg), b[3:0] > a[3:0]);
        end
        OP_INC: begin
          res_n = inc_r;
          wb_n  = 1'b1;
          flg_n = set_arith(flags, inc_r, sg, flags[FL_CF], inc_r == sg, a[3:0] == 4'hf);
        end
        OP_DEC: begin
          res_n = dec_r;
          wb_n  = 1'b1;
          flg_n = set_arith(flags, dec_r, sg, flags[FL_CF], a == sg, a[3:0] == 4'h0);
        end
        OP_NEG: begin
          res_n = neg_r;
          wb_n  = 1'b1;
          flg_n = set_arith(flags, neg_r, sg, a != 16'h0000, a == sg, a[3:0] != 4'h0);
        end
        OP_DIV, OP_IDIV: begin
          // Only a zero divisor reaches here.
          de_n = 1'b1;
        end
        OP_AND, OP_OR, OP_XOR, OP_TEST: begin
          res_n = (op == OP_TEST) ? 16'h0000 : lg_r;
          wb_n  = (op != OP_TEST);
          flg_n = set_arith(flags, lg_r, sg, 1'b0, 1'b0, 1'b0);
        end
        OP_NOT: begin
          res_n = ~a & mask;
          wb_n  = 1'b1;
        end
        OP_SHL, OP_SHR, OP_SAR: begin
          wb_n = 1'b1;
          if (sh_n == 6'd0) begin
            res_n = a;
          end else begin
            res_n = sh_r;
            flg_n[FL_CF] = sh_cf;
            flg_n[FL_OF] = |((a ^ sh_r) & sg);
            flg_n = set_common(flg_n, sh_r, sg);
          end
        end
        OP_CLC: flg_n[FL_CF] = 1'b0;
        OP_CMC: flg_n[FL_CF] = ~flags[FL_CF];
        OP_STC: flg_n[FL_CF] = 1'b1;
        OP_CLD: flg_n[FL_DF] = 1'b0;
        OP_STD: flg_n[FL_DF] = 1'b1;
        OP_CLI: flg_n[FL_IF] = 1'b0;
        OP_STI: flg_n[FL_IF] = 1'b1;
        // Odd conditions test the negated predicate.
        OP_BRT: br_n = cc_t ^ cond[0];
        default: ;
      endcase
    end
  end

  // Output register and kept flag word.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= 16'h0000;
    end else if (wr_n) begin
      flags <= flg_n;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n) begin
      result       <= res_n;
      write_back   <= wb_n;
      branch_taken <= br_n;
      divide_error <= de_n;
    end
  end

  assign flags_out = flags;

endmodule
`default_nettype wire

@@ hw/rtl/x86_16_alu_with_flags_unit.sv @@
// 8086-style ALU with a kept flag word.
// Input channel s_*: one transfer carries command, width, branch condition and
// two operands. Output channel m_*: one transfer per input item carries the
// masked result, write-back strobe, the flag word after the step, the
// branch-taken bit and the divide-error bit.
// One item is in flight at a time. Most operations are computed in the
// execute state and registered straight into the output; mul and imul first
// register the multiplier product and then form the result and flags; div and
// idiv pass a setup state, the 16 steps of the shared restoring divider and a
// state for the sign and flags. A zero divisor skips the divider and raises
// the divide-error bit. After the output transfer the unit passes through
// idle before it takes the next item.
// s_tready is high only while the unit is idle. While the receiver holds
// m_tready low the result stays on m_tdata and no new item is taken.
// A synchronous reset clears the flag word and returns the unit to idle.
`default_nettype none
module x86_16_alu_with_flags_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[4:0], wide[5], condition[9:6], operand_a[25:10], operand_b[41:26]
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result[15:0], write_back[16], flags_out[32:17], branch_taken[33],
  // divide_error[34]
  output logic [39:0]      m_tdata
);
  import x86alu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [15:0] result, flags_out;
  logic        write_back, branch_taken, divide_error;

  x86alu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  x86alu_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (s_tdata[4:0]),
    .wide         (s_tdata[5]),
    .condition    (s_tdata[9:6]),
    .operand_a    (s_tdata[25:10]),
    .operand_b    (s_tdata[41:26]),
    .result       (result),
    .write_back   (write_back),
    .flags_out    (flags_out),
    .branch_taken (branch_taken),
    .divide_error (divide_error)
  );

  assign m_tdata = {5'b0, divide_error, branch_taken, flags_out, write_back, result};

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
  import x86alu_pkg::*;

  localparam logic [15:0] M_CF = 16'h0001;
  localparam logic [15:0] M_PF = 16'h0004;
  localparam logic [15:0] M_AF = 16'h0010;
  localparam logic [15:0] M_ZF = 16'h0040;
  localparam logic [15:0] M_SF = 16'h0080;
  localparam logic [15:0] M_IF = 16'h0200;
  localparam logic [15:0] M_DF = 16'h0400;
  localparam logic [15:0] M_OF = 16'h0800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic [4:0]  command;
    logic        wide;
    logic [3:0]  condition;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } alu_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        write_back;
    logic [15:0] flags_out;
    logic        branch_taken;
    logic        divide_error;
  } alu_out_t;

  // One directed row: the item, and optionally the expected outcome.
  typedef struct {
    alu_item_t item;
    bit        typed;
    alu_out_t  want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  x86_16_alu_with_flags_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  logic [15:0] model_flags;
  alu_out_t    pending_results[$];
  int          error_count = 0;
  int          row_errors = 0;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          recv_hold;

  // Parity flag: even number of ones in the low byte.
  function automatic logic [15:0] common_flags(logic [15:0] fl, logic [15:0] r,
                                               logic [15:0] sign);
    fl &= ~(M_SF | M_ZF | M_PF);
    if ((r & sign) != 0) fl |= M_SF;
    if (r == 0) fl |= M_ZF;
    if (!(^r[7:0])) fl |= M_PF;
    return fl;
  endfunction

  function automatic logic [15:0] arith_flags(logic [15:0] fl, logic [15:0] r,
                                              logic [15:0] sign, bit cf, bit of, bit af);
    fl &= ~(M_CF | M_OF | M_AF);
    if (cf) fl |= M_CF;
    if (of) fl |= M_OF;
    if (af) fl |= M_AF;
    return common_flags(fl, r, sign);
  endfunction

  function automatic bit condition_holds(logic [15:0] fl, logic [3:0] c);
    bit cf, pf, zf, sf, of, t;
    cf = fl[FL_CF]; pf = fl[FL_PF]; zf = fl[FL_ZF]; sf = fl[FL_SF]; of = fl[FL_OF];
    case (c[3:1])
      3'd0: t = of;
      3'd1: t = cf;
      3'd2: t = zf;
      3'd3: t = cf | zf;
      3'd4: t = sf;
      3'd5: t = pf;
      3'd6: t = sf ^ of;
      default: t = (sf ^ of) | zf;
    endcase
    // Greater-than is the negation of less-or-equal; less-or-equal is taken as is.
    if (c == 4'd15) return !t;
    if (c == 4'd14) return t;
    return c[0] ? !t : t;
  endfunction

  // Computes the outcome of one item and advances the kept flag word.
  function automatic alu_out_t alu_predict(alu_item_t it);
    alu_out_t o;
    logic [31:0] mask, sign, a, b, u, p;
    int bits, n;
    logic signed [31:0] sa, sb, sq;
    logic [63:0] v, s;
    bit cf, hi;
    mask = it.wide ? 32'hffff : 32'hff;
    sign = it.wide ? 32'h8000 : 32'h80;
    bits = it.wide ? 16 : 8;
    a = it.operand_a & mask;
    b = it.operand_b & mask;
    o = '0;
    case (it.command)
      OP_ADD: begin
        u = a + b;
        o.result = 16'(u & mask); o.write_back = 1'b1;
        model_flags = arith_flags(model_flags, o.result, sign, (u & (sign << 1)) != 0,
          ((~(a ^ b)) & (a ^ u) & sign) != 0, ((a[3:0] + b[3:0]) & 16) != 0);
      end
      OP_SUB, OP_CMP: begin
        u = a - b;
        o.result = 16'(u & mask); o.write_back = (it.command == OP_SUB);
        model_flags = arith_flags(model_flags, o.result, sign, b > a,
          ((a ^ b) & (a ^ u) & sign) != 0, b[3:0] > a[3:0]);
        if (it.command == OP_CMP) o.result = 16'h0000;
      end
      OP_INC: begin
        o.result = 16'((a + 1) & mask); o.write_back = 1'b1;
        model_flags = arith_flags(model_flags, o.result, sign, model_flags[FL_CF],
          o.result == sign, a[3:0] == 4'hf);
      end
      OP_DEC: begin
        o.result = 16'((a - 1) & mask); o.write_back = 1'b1;
        model_flags = arith_flags(model_flags, o.result, sign, model_flags[FL_CF],
          a == sign, a[3:0] == 4'h0);
      end
      OP_NEG: begin
        o.result = 16'((0 - a) & mask); o.write_back = 1'b1;
        model_flags = arith_flags(model_flags, o.result, sign, a != 0, a == sign,
          a[3:0] != 0);
      end
      OP_MUL: begin
        p = a * b;
        hi = (p >> bits) != 0;
        o.result = 16'(p & mask); o.write_back = 1'b1;
        model_flags = arith_flags(model_flags, o.result, sign, hi, hi, 1'b0);
      end
      OP_IMUL: begin
        sa = (a & sign) ? (a | ~mask) : a;
        sb = (b & sign) ? (b | ~mask) : b;
        p = sa * sb;
        u = p & mask;
        if (u & sign) u = u | ~mask;
        hi = u != p;
        o.result = 16'(p & mask); o.write_back = 1'b1;
        model_flags = arith_flags(model_flags, o.result, sign, hi, hi, 1'b0);
      end
      OP_DIV, OP_IDIV: begin
        if (b == 0) begin
          o.divide_error = 1'b1;
        end else begin
          if (it.command == OP_DIV) begin
            o.result = 16'((a / b) & mask);
          end else begin
            sa = (a & sign) ? (a | ~mask) : a;
            sb = (b & sign) ? (b | ~mask) : b;
            // Signed quotient, rounded toward zero.
            sq = sa / sb;
            o.result = 16'(sq & mask);
          end
          o.write_back = 1'b1;
          model_flags = arith_flags(model_flags, o.result, sign, 1'b0, 1'b0, 1'b0);
        end
      end
      OP_AND, OP_OR, OP_XOR, OP_TEST: begin
        u = (it.command == OP_OR) ? (a | b) : (it.command == OP_XOR) ? (a ^ b) : (a & b);
        o.result = 16'(u); o.write_back = (it.command != OP_TEST);
        model_flags = arith_flags(model_flags, o.result, sign, 1'b0, 1'b0, 1'b0);
        if (it.command == OP_TEST) o.result = 16'h0000;
      end
      OP_NOT: begin
        o.result = 16'((~a) & mask); o.write_back = 1'b1;
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        n = (b > 32) ? 32 : b;
        o.write_back = 1'b1;
        if (n == 0) begin
          o.result = 16'(a);
        end else begin
          if (it.command == OP_SHL) begin
            s = {32'b0, a} << n;
            cf = s[bits];
          end else begin
            v = (it.command == OP_SAR && (a & sign) != 0) ? ({32'b0, a} | ~{32'b0, mask})
                                                            : {32'b0, a};
            s = v >> n;
            cf = v[n - 1];
          end
          o.result = s[15:0] & mask[15:0];
          model_flags &= ~(M_CF | M_OF);
          if (cf) model_flags |= M_CF;
          if ((a & sign) != (o.result & sign)) model_flags |= M_OF;
          model_flags = common_flags(model_flags, o.result, sign);
        end
      end
      OP_CLC: model_flags &= ~M_CF;
      OP_CMC: model_flags ^= M_CF;
      OP_STC: model_flags |= M_CF;
      OP_CLD: model_flags &= ~M_DF;
      OP_STD: model_flags |= M_DF;
      OP_CLI: model_flags &= ~M_IF;
      OP_STI: model_flags |= M_IF;
      OP_BRT: o.branch_taken = condition_holds(model_flags, it.condition);
      default: ;
    endcase
    o.flags_out = model_flags;
    return o;
  endfunction

  function automatic alu_item_t make_item(op_t cmd, bit w, logic [15:0] a, logic [15:0] b);
    alu_item_t it;
    it.command = cmd; it.wide = w; it.condition = 4'd0;
    it.operand_a = a; it.operand_b = b;
    return it;
  endfunction

  // Random item; operands favor edge values, shifts favor small counts.
  function automatic alu_item_t random_item();
    alu_item_t it;
    it = alu_item_t'(42'({$urandom, $urandom}));
    it.command = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(26, 31))
                                              : 5'($urandom_range(0, 25));
    case ($urandom_range(0, 5))
      0: it.operand_a = {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'h80 : 8'h7f};
      1: it.operand_b = $urandom_range(0, 3) == 0 ? 16'h0 : 16'hffff;
      default: ;
    endcase
    if (it.command inside {OP_SHL, OP_SHR, OP_SAR} && $urandom_range(0, 3) != 0)
      it.operand_b = 16'($urandom_range(0, 40));
    return it;
  endfunction

  // Offers one item and waits for its transfer; the expectation is queued
  // at the transfer edge.
  task automatic send_item(alu_item_t it, bit typed, alu_out_t want);
    alu_out_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {6'b0, it.operand_b, it.operand_a, it.condition, it.wide, it.command};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    got = alu_predict(it);
    if (typed && got != want) begin
      $error("directed row predicted %h, table gives %h", got, want);
      row_errors++;
    end
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (rst || recv_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compares each output transfer with the oldest expectation.
  always @(posedge clk) begin
    alu_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[16], m_tdata[32:17], m_tdata[33], m_tdata[34]};
      if (pending_results.size() == 0) begin
        $error("unexpected output transfer %h", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.result != want.result) begin
          $error("result: expected %h, actual %h", want.result, got.result); error_count++;
        end
        if (got.write_back != want.write_back) begin
          $error("write_back: expected %b, actual %b", want.write_back, got.write_back);
          error_count++;
        end
        if (got.flags_out != want.flags_out) begin
          $error("flags_out: expected %h, actual %h", want.flags_out, got.flags_out);
          error_count++;
        end
        if (got.branch_taken != want.branch_taken) begin
          $error("branch_taken: expected %b, actual %b", want.branch_taken, got.branch_taken);
          error_count++;
        end
        if (got.divide_error != want.divide_error) begin
          $error("divide_error: expected %b, actual %b", want.divide_error, got.divide_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    alu_out_t nul;
    int phase;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    recv_hold = 0; send_idle_pct = 0; recv_stall_pct = 0;
    model_flags = '0;
    nul = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: typed rows where the outcome is obvious, untyped rows checked against the prediction.
    rows.push_back('{make_item(OP_BRT, 0, 0, 0), 1, '{0, 0, 16'h0000, 0, 0}});
    rows.push_back('{make_item(OP_STC, 0, 16'hffff, 16'hffff), 1, '{0, 0, 16'h0001, 0, 0}});
    rows.push_back('{make_item(OP_STD, 1, 0, 0), 1, '{0, 0, 16'h0401, 0, 0}});
    rows.push_back('{make_item(OP_STI, 1, 0, 0), 1, '{0, 0, 16'h0601, 0, 0}});
    rows.push_back('{make_item(OP_CMC, 1, 0, 0), 1, '{0, 0, 16'h0600, 0, 0}});
    rows.push_back('{make_item(OP_DIV, 1, 16'h1234, 0), 1, '{0, 0, 16'h0600, 0, 1}});
    rows.push_back('{make_item(OP_IDIV, 0, 16'hff80, 16'hff00), 1, '{0, 0, 16'h0600, 0, 1}});
    rows.push_back('{make_item(OP_CLI, 0, 0, 0), 1, '{0, 0, 16'h0400, 0, 0}});
    rows.push_back('{make_item(OP_CLD, 0, 0, 0), 1, '{0, 0, 16'h0000, 0, 0}});
    rows.push_back('{make_item(OP_ADD, 0, 16'h00ff, 16'h0001), 0, nul});
    rows.push_back('{make_item(OP_ADD, 1, 16'h7fff, 16'h0001), 0, nul});
    rows.push_back('{make_item(OP_SUB, 1, 16'h0000, 16'hffff), 0, nul});
    rows.push_back('{make_item(OP_CMP, 0, 16'h0080, 16'h0001), 0, nul});
    rows.push_back('{make_item(OP_INC, 0, 16'h007f, 0), 0, nul});
    rows.push_back('{make_item(OP_DEC, 1, 16'h8000, 0), 0, nul});
    rows.push_back('{make_item(OP_NEG, 1, 16'h8000, 0), 0, nul});
    rows.push_back('{make_item(OP_MUL, 1, 16'hffff, 16'hffff), 0, nul});
    rows.push_back('{make_item(OP_IMUL, 0, 16'h0080, 16'h00ff), 0, nul});
    rows.push_back('{make_item(OP_IDIV, 1, 16'h8000, 16'hffff), 0, nul});
    rows.push_back('{make_item(OP_DIV, 0, 16'h00ff, 16'h0007), 0, nul});
    rows.push_back('{make_item(OP_TEST, 1, 16'hf0f0, 16'h0f0f), 0, nul});
    rows.push_back('{make_item(OP_NOT, 1, 16'h5a5a, 0), 0, nul});
    rows.push_back('{make_item(OP_SHL, 1, 16'h8001, 16'h0000), 0, nul});
    rows.push_back('{make_item(OP_SAR, 0, 16'h0081, 16'h00ff), 0, nul});
    rows.push_back('{make_item(OP_SHR, 1, 16'hffff, 16'h0020), 0, nul});
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.item, row.typed, row.want);
    end
    foreach (rows[i]) begin
      row = rows[i];
      row.item.command = OP_BRT;
      row.item.condition = 4'(i % 16);
      send_item(row.item, 0, nul);
    end

    // Random part over the idling phases.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase == 4) begin
        // Long receiver hold-off while items keep being offered.
        fork
          begin
            recv_hold = 1;
            repeat (200) @(negedge clk);
            recv_hold = 0;
          end
        join_none
      end
      repeat (RANDOM_ITEMS / 5) send_item(random_item(), 0, nul);
      // Sender pauses until every result is back.
      while (pending_results.size() != 0) @(negedge clk);
    end

    repeat (30) @(negedge clk);
    if (error_count == 0 && row_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/x86alu_pkg.sv
hw/rtl/x86alu_ctrl.sv
hw/rtl/x86alu_dpath.sv
hw/rtl/x86_16_alu_with_flags_unit.sv
sim/tb_top.sv
